// ===== rtl/core/sphere_sphere_contact_macros.svh =====
// Assertion macros for the sphere contact block.
`ifndef SPHERE_SPHERE_CONTACT_MACROS_SVH
`define SPHERE_SPHERE_CONTACT_MACROS_SVH
`ifndef SYNTHESIS
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SSC_ASSERT(lbl, prop, msg)
`define SSC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/ssc_pkg.sv =====
`default_nettype none
package ssc_pkg;
  localparam int unsigned COORD_W  = 28;
  localparam int unsigned RADIUS_W = 27;
  localparam int unsigned NORM_W   = 18;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned UNIT_W   = 32;
  localparam int unsigned CAP_W    = 9;
  localparam logic [CAP_W-1:0] LIST_LIMIT = 9'd256;
  localparam logic [CAP_W-1:0] CAP_RESET  = 9'd64;

  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_CONTACT = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_CLEARED = 2'd3
  } status_t;

  localparam logic CMD_TEST  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } ssc_sub_t;
endpackage
`default_nettype wire

// ===== rtl/core/ssc_sub_unit.sv =====
`default_nettype none
// Shared compare-and-subtract step used by both the square root and the divider.
module ssc_sub_unit (
  input  wire logic [ssc_pkg::UNIT_W-1:0] a,
  input  wire logic [ssc_pkg::UNIT_W-1:0] b,
  output ssc_pkg::ssc_sub_t               res
);
  import ssc_pkg::*;
  logic [UNIT_W:0] full;
  assign full     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~full[UNIT_W];
  assign res.diff = full[UNIT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/sphere_sphere_contact.sv =====
`default_nettype none
// Channel   Handshake                 Direction  Payload
// item      item_valid / item_stall   in         cmd, sphere centers, radii, ids
// result    result_valid / result_stall out      status, point, normal, depth, slot, ids
// config    APB (psel..pready)        in/out     max_contacts at address 0
// A touching pair holds the input while it is accepted, squared and summed on one multiplier,
// put through 29 root steps and 3 x 18 divider steps on the shared compare-subtract unit,
// and loaded into the result. A pair found apart ends at the first divider step. A clear or
// a test on a full list goes straight from the accepting state to the result.
// Reset is synchronous; it empties the list and restores a capacity of 64.
// item_stall is high whenever a word is in work or waits to be loaded into the result.
module sphere_sphere_contact (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         cmd,
  input  wire logic signed [ssc_pkg::COORD_W-1:0]  first_x,
  input  wire logic signed [ssc_pkg::COORD_W-1:0]  first_y,
  input  wire logic signed [ssc_pkg::COORD_W-1:0]  first_z,
  input  wire logic [ssc_pkg::RADIUS_W-1:0]        first_radius,
  input  wire logic signed [ssc_pkg::COORD_W-1:0]  second_x,
  input  wire logic signed [ssc_pkg::COORD_W-1:0]  second_y,
  input  wire logic signed [ssc_pkg::COORD_W-1:0]  second_z,
  input  wire logic [ssc_pkg::RADIUS_W-1:0]        second_radius,
  input  wire logic [ssc_pkg::ID_W-1:0]            first_id,
  input  wire logic [ssc_pkg::ID_W-1:0]            second_id,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic [1:0]                        status,
  output logic signed [ssc_pkg::COORD_W-1:0] point_x,
  output logic signed [ssc_pkg::COORD_W-1:0] point_y,
  output logic signed [ssc_pkg::COORD_W-1:0] point_z,
  output logic signed [ssc_pkg::NORM_W-1:0]  normal_x,
  output logic signed [ssc_pkg::NORM_W-1:0]  normal_y,
  output logic signed [ssc_pkg::NORM_W-1:0]  normal_z,
  output logic [ssc_pkg::COORD_W-1:0]       depth,
  output logic [7:0]                        slot,
  output logic [ssc_pkg::ID_W-1:0]          out_first_id,
  output logic [ssc_pkg::ID_W-1:0]          out_second_id
);
  import ssc_pkg::*;
`include "sphere_sphere_contact_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_ROOT   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;
  logic [CAP_W-1:0] max_contacts, capacity, used_count;
  logic item_accept, load;
  status_t res_status;

  logic [COORD_W:0]   in_mag [3];
  logic               in_neg [3];
  logic [COORD_W-1:0] in_mid [3];
  logic signed [COORD_W:0] dif [3];
  logic signed [COORD_W:0] sum [3];

  logic [COORD_W:0]   mag [3];
  logic               neg [3];
  logic [COORD_W-1:0] mid [3];
  logic [COORD_W-1:0] rsum;
  logic [ID_W-1:0]    id_a, id_b;
  logic [NORM_W-1:0]  nrm [3];

  logic [4:0]  step;
  logic [1:0]  axis;
  logic [57:0] prod, acc, sq;
  logic [COORD_W:0] mult_in, root;
  logic [UNIT_W-1:0] rem, unit_a, unit_b;
  logic [16:0] low, quot, quot_next;
  ssc_sub_t unit_res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, max_contacts} : 32'd0;
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign load = (state == ST_DONE) && (!result_valid || !result_stall);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_mag[k] = '0;
      in_neg[k] = 1'b0;
      in_mid[k] = '0;
    end
    dif[0] = {first_x[COORD_W-1], first_x} - {second_x[COORD_W-1], second_x};
    dif[1] = {first_y[COORD_W-1], first_y} - {second_y[COORD_W-1], second_y};
    dif[2] = {first_z[COORD_W-1], first_z} - {second_z[COORD_W-1], second_z};
    sum[0] = {first_x[COORD_W-1], first_x} + {second_x[COORD_W-1], second_x};
    sum[1] = {first_y[COORD_W-1], first_y} + {second_y[COORD_W-1], second_y};
    sum[2] = {first_z[COORD_W-1], first_z} + {second_z[COORD_W-1], second_z};
    for (int k = 0; k < 3; k++) begin
      in_neg[k] = dif[k][COORD_W];
      in_mag[k] = dif[k][COORD_W] ? -dif[k] : dif[k];
      // Arithmetic shift gives the floor of the half sum.
      in_mid[k] = sum[k][COORD_W:1];
    end
  end

  always_comb begin
    unique case (step[1:0])
      2'd0:    mult_in = mag[0];
      2'd1:    mult_in = mag[1];
      2'd2:    mult_in = mag[2];
      default: mult_in = '0;
    endcase
  end

  always_comb begin
    if (state == ST_ROOT) begin
      unit_a = {rem[29:0], sq[57:56]};
      unit_b = {1'b0, root, 2'b01};
    end else begin
      unit_a = {rem[30:0], low[16]};
      unit_b = {2'b00, root, 1'b0};
    end
  end

  ssc_sub_unit u_sub (.a(unit_a), .b(unit_b), .res(unit_res));

  assign quot_next = {quot[15:0], unit_res.ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_contacts <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_contacts <= pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used_count   <= '0;
      capacity     <= CAP_RESET;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_accept) begin
            if (cmd == CMD_CLEAR) begin
              used_count <= '0;
              capacity   <= (max_contacts > LIST_LIMIT) ? LIST_LIMIT : max_contacts;
              res_status <= STATUS_CLEARED;
              state      <= ST_DONE;
            end else if (used_count >= capacity) begin
              res_status <= STATUS_FULL;
              state      <= ST_DONE;
            end else begin
              for (int k = 0; k < 3; k++) begin
                mag[k] <= in_mag[k];
                neg[k] <= in_neg[k];
                mid[k] <= in_mid[k];
              end
              rsum  <= {1'b0, first_radius} + {1'b0, second_radius};
              id_a  <= first_id;
              id_b  <= second_id;
              step  <= '0;
              acc   <= '0;
              state <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          prod <= 58'(mult_in * mult_in);
          if (step != 5'd0) acc <= acc + prod;
          if (step == 5'd3) begin
            sq    <= acc + prod;
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= ST_ROOT;
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_ROOT: begin
          rem  <= unit_res.ge ? unit_res.diff : unit_a;
          root <= {root[COORD_W-1:0], unit_res.ge};
          sq   <= {sq[55:0], 2'b00};
          if (step == 5'd28) begin
            step  <= '0;
            axis  <= '0;
            state <= ST_DIVIDE;
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_DIVIDE: begin
          if (step == 5'd0) begin
            if (axis == 2'd0 && (root == '0 || root >= {1'b0, rsum})) begin
              res_status <= STATUS_NONE;
              state      <= ST_DONE;
            end else begin
              // Quotient of (mag << 17) + d over 2d; the high part starts the remainder.
              rem  <= UNIT_W'(mag[axis]) + UNIT_W'(root[COORD_W:17]);
              low  <= root[16:0];
              quot <= '0;
              step <= 5'd1;
            end
          end else begin
            rem  <= unit_res.ge ? unit_res.diff : unit_a;
            low  <= {low[15:0], 1'b0};
            quot <= quot_next;
            if (step == 5'd17) begin
              nrm[axis] <= neg[axis] ? -{1'b0, quot_next} : {1'b0, quot_next};
              step      <= '0;
              if (axis == 2'd2) begin
                res_status <= STATUS_CONTACT;
                state      <= ST_DONE;
              end else begin
                axis <= axis + 2'd1;
              end
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
            if (res_status == STATUS_CONTACT) used_count <= used_count + 9'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= res_status;
      if (res_status == STATUS_CONTACT) begin
        point_x       <= mid[0];
        point_y       <= mid[1];
        point_z       <= mid[2];
        normal_x      <= nrm[0];
        normal_y      <= nrm[1];
        normal_z      <= nrm[2];
        depth         <= rsum - root[COORD_W-1:0];
        slot          <= used_count[7:0];
        out_first_id  <= id_a;
        out_second_id <= id_b;
      end else begin
        point_x       <= '0;
        point_y       <= '0;
        point_z       <= '0;
        normal_x      <= '0;
        normal_y      <= '0;
        normal_z      <= '0;
        depth         <= '0;
        slot          <= '0;
        out_first_id  <= '0;
        out_second_id <= '0;
      end
    end
  end

  `SSC_ASSERT_NEVER(a_count_bound, used_count > LIST_LIMIT, "contact count above list limit")
  `SSC_ASSERT(a_contact_depth, result_valid && status == STATUS_CONTACT |-> depth != '0, "contact with zero depth")
  `SSC_ASSERT(a_slot_claim, load && res_status == STATUS_CONTACT |=> used_count == $past(used_count) + 9'd1, "slot not claimed")
  `SSC_ASSERT(a_no_accept_busy, state != ST_IDLE |-> !item_accept, "word taken while busy")
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import ssc_pkg::*;

  typedef struct {
    logic                cmd;
    logic signed [27:0]  ax, ay, az, bx, by, bz;
    logic [26:0]         ra, rb;
    logic [15:0]         ida, idb;
  } pair_t;

  typedef struct {
    status_t             st;
    logic signed [27:0]  px, py, pz;
    logic signed [17:0]  nx, ny, nz;
    logic [27:0]         dep;
    logic [7:0]          slot;
    logic [15:0]         ida, idb;
  } contact_t;

  // Contact predictor and the queue of contacts it expects.
  class contact_board;
    logic [8:0] max_contacts;
    logic [8:0] used_count;
    logic [8:0] capacity;
    contact_t   pending[$];
    int         errors;

    function new();
      max_contacts = CAP_RESET;
      used_count = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function automatic longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Rounded to nearest, ties away from zero, saturated to one.
    function automatic logic signed [17:0] unit(longint m, longint unsigned d);
      longint unsigned mag, q;
      mag = (m < 0) ? -m : m;
      q = ((mag << 17) + d) / (d << 1);
      if (q > 65536) q = 65536;
      return (m < 0) ? -q : q;
    endfunction

    function void note_pair(pair_t p);
      contact_t c;
      longint a[3], b[3], m[3];
      longint unsigned s, d, rsum;
      c = '{st: STATUS_NONE, default: '0};
      if (p.cmd == CMD_CLEAR) begin
        used_count = 0;
        capacity = (max_contacts > LIST_LIMIT) ? LIST_LIMIT : max_contacts;
        c.st = STATUS_CLEARED;
      end else if (used_count >= capacity) begin
        c.st = STATUS_FULL;
      end else begin
        a = '{p.ax, p.ay, p.az};
        b = '{p.bx, p.by, p.bz};
        s = 0;
        for (int i = 0; i < 3; i++) begin
          m[i] = a[i] - b[i];
          s += m[i] * m[i];
        end
        d = root(s);
        rsum = p.ra + p.rb;
        if (d != 0 && d < rsum) begin
          c.st = STATUS_CONTACT;
          c.px = (a[0] + b[0]) >>> 1;
          c.py = (a[1] + b[1]) >>> 1;
          c.pz = (a[2] + b[2]) >>> 1;
          c.nx = unit(m[0], d);
          c.ny = unit(m[1], d);
          c.nz = unit(m[2], d);
          c.dep = rsum - d;
          c.slot = used_count[7:0];
          c.ida = p.ida;
          c.idb = p.idb;
          used_count++;
        end
      end
      pending.push_back(c);
    endfunction

    function void check_contact(contact_t got);
      contact_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word, status %0d", got.st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.st !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, got.st); errors++;
      end
      if (got.px !== e.px) begin
        $error("point_x: expected %0d, got %0d", e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
        $error("point_y: expected %0d, got %0d", e.py, got.py); errors++;
      end
      if (got.pz !== e.pz) begin
        $error("point_z: expected %0d, got %0d", e.pz, got.pz); errors++;
      end
      if (got.nx !== e.nx) begin
        $error("normal_x: expected %0d, got %0d", e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $error("normal_y: expected %0d, got %0d", e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $error("normal_z: expected %0d, got %0d", e.nz, got.nz); errors++;
      end
      if (got.dep !== e.dep) begin
        $error("depth: expected %0d, got %0d", e.dep, got.dep); errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot: expected %0d, got %0d", e.slot, got.slot); errors++;
      end
      if (got.ida !== e.ida) begin
        $error("out_first_id: expected %0d, got %0d", e.ida, got.ida); errors++;
      end
      if (got.idb !== e.idb) begin
        $error("out_second_id: expected %0d, got %0d", e.idb, got.idb); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic item_valid, item_stall, result_valid, result_stall;
  logic cmd;
  logic signed [27:0] first_x, first_y, first_z, second_x, second_y, second_z;
  logic [26:0] first_radius, second_radius;
  logic [15:0] first_id, second_id;
  logic [1:0] status;
  logic signed [27:0] point_x, point_y, point_z;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic [27:0] depth;
  logic [7:0] slot;
  logic [15:0] out_first_id, out_second_id;

  contact_board board;
  bit  stim_done;
  int  cycles;
  localparam int CYCLE_LIMIT = 2000000;

  sphere_sphere_contact DUT (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    item_valid = 0; result_stall = 0; cmd = CMD_TEST;
    first_x = 0; first_y = 0; first_z = 0; first_radius = 0;
    second_x = 0; second_y = 0; second_z = 0; second_radius = 0;
    first_id = 0; second_id = 0;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_capacity(logic [8:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= '0; pwdata <= {23'd0, v};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.max_contacts = v;
  endtask

  task automatic send_word(pair_t p);
    cmd <= p.cmd;
    first_x <= p.ax; first_y <= p.ay; first_z <= p.az; first_radius <= p.ra;
    second_x <= p.bx; second_y <= p.by; second_z <= p.bz; second_radius <= p.rb;
    first_id <= p.ida; second_id <= p.idb;
    item_valid <= 1;
    do @(posedge clk); while (item_stall);
    board.note_pair(p);
  endtask

  task automatic send_gap(pair_t p, bit idle);
    int g;
    g = idle ? $urandom_range(0, 14) : 0;
    if (g > 0) begin
      item_valid <= 0;
      repeat (g) @(posedge clk);
    end
    send_word(p);
  endtask

  task automatic drain();
    item_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [27:0] rcoord();
    return $urandom;
  endfunction

  // Mostly nearby sphere pairs so that many of them touch.
  function automatic pair_t rand_pair();
    pair_t p;
    int sp;
    p.cmd = ($urandom_range(0, 40) == 0) ? CMD_CLEAR : CMD_TEST;
    p.ida = $urandom; p.idb = $urandom;
    case ($urandom_range(0, 5))
      0: begin
        p.ax = rcoord(); p.ay = rcoord(); p.az = rcoord();
        p.bx = rcoord(); p.by = rcoord(); p.bz = rcoord();
        p.ra = $urandom; p.rb = $urandom;
      end
      1: begin
        p.ax = rcoord(); p.ay = rcoord(); p.az = rcoord();
        p.bx = p.ax; p.by = p.ay; p.bz = p.az;
        if ($urandom_range(0, 1)) p.bz = p.az + 1;
        p.ra = $urandom_range(0, 3); p.rb = $urandom_range(0, 3);
      end
      default: begin
        sp = 1 << $urandom_range(2, 24);
        p.ax = rcoord() >>> 1; p.ay = rcoord() >>> 1; p.az = rcoord() >>> 1;
        p.bx = p.ax + $signed($urandom_range(0, 2 * sp)) - sp;
        p.by = p.ay + $signed($urandom_range(0, 2 * sp)) - sp;
        p.bz = p.az + $signed($urandom_range(0, 2 * sp)) - sp;
        p.ra = $urandom_range(0, 2 * sp); p.rb = $urandom_range(0, 2 * sp);
      end
    endcase
    return p;
  endfunction

  function automatic pair_t mk(logic c, logic signed [27:0] ax, ay, az, bx, by, bz,
                               logic [26:0] ra, rb);
    pair_t p;
    p = '{cmd: c, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, ra: ra, rb: rb,
          ida: $urandom, idb: $urandom};
    return p;
  endfunction

  localparam logic signed [27:0] CMAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] CMIN = -28'sh8000000;
  localparam logic [26:0] RMAX = 27'h7FFFFFF;

  // Result side with random stalls.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      board.check_contact('{st: status_t'(status), px: point_x, py: point_y, pz: point_z,
                             nx: normal_x, ny: normal_y, nz: normal_z, dep: depth,
                             slot: slot, ida: out_first_id, idb: out_second_id});
  end

  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = stim_done ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) w = 0;
      result_stall <= (w != 0);
      if (w != 0) begin
        repeat (w) @(posedge clk);
        result_stall <= 0;
      end
      @(posedge clk);
    end
  end

  initial begin
    pair_t p;
    logic [8:0] caps[6];
    bit idle;
    wait (rst === 0);
    @(posedge clk);
    caps = '{9'd0, 9'd1, 9'd3, 9'd256, 9'd511, 9'd64};
    // Directed: extremes, coincident centers, edge of contact, full and cleared list.
    send_word(mk(CMD_TEST, 0, 0, 0, 0, 0, 0, RMAX, RMAX));
    send_word(mk(CMD_TEST, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, RMAX, RMAX));
    send_word(mk(CMD_TEST, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, RMAX, RMAX));
    send_word(mk(CMD_TEST, 100, 0, 0, 0, 0, 0, 50, 50));
    send_word(mk(CMD_TEST, 100, 0, 0, 0, 0, 0, 50, 51));
    send_word(mk(CMD_TEST, 1, 0, 0, 0, 0, 0, 0, 2));
    send_word(mk(CMD_TEST, -3, -5, 7, 0, 0, 0, 9, 9));
    send_word(mk(CMD_TEST, CMAX, 0, 0, CMAX - 1, 0, 0, 0, 0));
    send_word(mk(CMD_TEST, 0, CMIN, 0, 0, CMAX, 0, RMAX, RMAX));
    p = mk(CMD_TEST, 1, 1, 1, 0, 0, 0, 5, 5); p.ida = 16'hFFFF; p.idb = 16'h0;
    send_word(p);
    drain();
    write_capacity(9'd2);
    send_word(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_word(mk(CMD_TEST, 10, 20, 30, 0, 0, 0, 40, 40));
    drain();
    // Random phases, each under its own capacity.
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(caps[ph]);
      send_word(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      idle = (ph % 2 == 0);
      for (int i = 0; i < 205; i++) begin
        if (i == 100) drain();
        send_gap(rand_pair(), idle || (i % 50 < 25));
      end
      drain();
    end
    stim_done = 1;
    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire
